FILE: design/wss_pkg.sv
// shared widths, codes and result type of the work-stealing scheduler
package wss_pkg;

  // fixed field widths
  localparam int OP_W       = 1;
  localparam int WORKER_W   = 3;
  localparam int TASK_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OP_W-1:0] OP_GET  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GROUP    = 1'b1;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] WORKERS_IN_USE_RST = 4'd8;
  localparam logic [CFG_DATA_W-1:0] FIRST_GROUP_RST    = 4'd0;

  // one result item
  typedef struct packed {
    logic                found;
    logic [TASK_W-1:0]   task_out;
    logic [WORKER_W-1:0] source_worker;
    logic                stolen;
    logic                overflow;
  } result_t;

endpackage

FILE: design/wss_req_if.sv
// request channel: operation, worker and task number
interface wss_req_if;
  logic                          valid;
  logic                          ready;
  logic [wss_pkg::OP_W-1:0]      operation;
  logic [wss_pkg::WORKER_W-1:0]  worker;
  logic [wss_pkg::TASK_W-1:0]    task_req;

  modport source (output valid, operation, worker, task_req, input ready);
  modport sink   (input valid, operation, worker, task_req, output ready);
endinterface

FILE: design/wss_res_if.sv
// result channel: returned task and status flags
interface wss_res_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [wss_pkg::TASK_W-1:0]    task_out;
  logic [wss_pkg::WORKER_W-1:0]  source_worker;
  logic                          stolen;
  logic                          overflow;

  modport source (output valid, found, task_out, source_worker, stolen, overflow,
                  input ready);
  modport sink   (input valid, found, task_out, source_worker, stolen, overflow,
                  output ready);
endinterface

FILE: design/wss_cfg_if.sv
// configuration write channel: register index and data
interface wss_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wss_pkg::CFG_IDX_W-1:0]   index;
  logic [wss_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/wss_ram.sv
// generic single-port-write, single-port-read ram with registered read
module wss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/wss_ctrl.sv
// sequencer with deque counters, shared size/compare unit and task ram
module wss_ctrl #(
  parameter int WORKERS = 8,
  parameter int DEPTH   = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              ready,
  input  logic [wss_pkg::OP_W-1:0]          op,
  input  logic [wss_pkg::WORKER_W-1:0]      worker,
  input  logic [wss_pkg::TASK_W-1:0]        task_req,
  input  logic [wss_pkg::CFG_DATA_W-1:0]    live_n,
  input  logic [wss_pkg::CFG_DATA_W-1:0]    group_n,
  output logic                              res_valid,
  output wss_pkg::result_t                  res,
  input  logic                              res_take
);

  localparam int WIDX  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int SW    = $clog2(DEPTH);
  localparam int SIZEW = $clog2(DEPTH + 1);
  localparam int AW    = WIDX + SW;
  localparam int CW    = wss_pkg::CFG_DATA_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_STEAL = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [SW-1:0]    SLOT_LAST = SW'(DEPTH - 1);
  localparam logic [SIZEW-1:0] SIZE_FULL = SIZEW'(DEPTH);

  // deque counters: slot position plus a wrap bit, i.e. count modulo 2*DEPTH
  logic [SW-1:0] top_slot_r [WORKERS];
  logic          top_wrap_r [WORKERS];
  logic [SW-1:0] bot_slot_r [WORKERS];
  logic          bot_wrap_r [WORKERS];

  logic [2:0]                     state_r, state_nxt;
  logic [wss_pkg::OP_W-1:0]       op_r;
  logic [wss_pkg::WORKER_W-1:0]   w_r;
  logic [wss_pkg::TASK_W-1:0]     task_r;
  logic [CW-1:0]                  n_r, g_r;
  logic [CW-1:0]                  scan_r, scan_nxt;
  logic [CW-1:0]                  hi_r, hi_nxt;
  logic                           phase2_r, phase2_nxt;
  logic [WIDX-1:0]                best_r, best_nxt;
  logic                           best_ok_r, best_ok_nxt;
  logic [SIZEW-1:0]               best_size_r, best_size_nxt;
  wss_pkg::result_t               res_r, res_nxt;

  logic [WIDX-1:0]  sel;
  logic [SW-1:0]    t_slot, b_slot, t_slot_inc, b_slot_inc, b_slot_dec;
  logic             t_wrap, b_wrap, t_wrap_inc, b_wrap_inc, b_wrap_dec;
  logic [SIZEW-1:0] size;
  logic             full, empty, own_ok;

  logic             top_we, bot_we;
  logic [SW-1:0]    top_wslot, bot_wslot;
  logic             top_wwrap, bot_wwrap;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [wss_pkg::TASK_W-1:0] ram_rdata;

  // single counter read index, chosen by the sequencer state
  always_comb begin
    case (state_r)
      S_SCAN:  sel = WIDX'(scan_r);
      S_STEAL: sel = best_r;
      default: sel = WIDX'(w_r);
    endcase
  end

  // shared size unit on the selected deque
  always_comb begin
    t_slot = top_slot_r[sel];
    t_wrap = top_wrap_r[sel];
    b_slot = bot_slot_r[sel];
    b_wrap = bot_wrap_r[sel];
    if (t_wrap == b_wrap) begin
      size = SIZEW'(b_slot) - SIZEW'(t_slot);
    end else begin
      size = SIZE_FULL + SIZEW'(b_slot) - SIZEW'(t_slot);
    end
    full  = (size == SIZE_FULL);
    empty = (size == '0);
    t_slot_inc = (t_slot == SLOT_LAST) ? '0 : t_slot + 1'b1;
    t_wrap_inc = (t_slot == SLOT_LAST) ? ~t_wrap : t_wrap;
    b_slot_inc = (b_slot == SLOT_LAST) ? '0 : b_slot + 1'b1;
    b_wrap_inc = (b_slot == SLOT_LAST) ? ~b_wrap : b_wrap;
    b_slot_dec = (b_slot == '0) ? SLOT_LAST : b_slot - 1'b1;
    b_wrap_dec = (b_slot == '0) ? ~b_wrap : b_wrap;
  end

  assign own_ok = ({1'b0, w_r} < n_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    hi_nxt        = hi_r;
    phase2_nxt    = phase2_r;
    best_nxt      = best_r;
    best_ok_nxt   = best_ok_r;
    best_size_nxt = best_size_r;
    res_nxt       = res_r;
    top_we        = 1'b0;
    bot_we        = 1'b0;
    top_wslot     = t_slot_inc;
    top_wwrap     = t_wrap_inc;
    bot_wslot     = b_slot_inc;
    bot_wwrap     = b_wrap_inc;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = {sel, b_slot};
    ram_raddr     = {sel, b_slot_dec};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt   = '0;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!own_ok) begin
          state_nxt = S_DONE;
        end else if (op_r == wss_pkg::OP_PUSH) begin
          // append at the bottom or flag a full deque
          if (full) begin
            res_nxt.overflow = 1'b1;
          end else begin
            ram_we = 1'b1;
            bot_we = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (!empty) begin
          // pop newest from own deque; last task advances top instead
          ram_re = 1'b1;
          if (size == SIZEW'(1)) begin
            top_we = 1'b1;
          end else begin
            bot_we    = 1'b1;
            bot_wslot = b_slot_dec;
            bot_wwrap = b_wrap_dec;
          end
          res_nxt.found         = 1'b1;
          res_nxt.source_worker = w_r;
          state_nxt             = S_READ;
        end else begin
          // own deque empty: search the first group for a victim
          scan_nxt      = '0;
          hi_nxt        = g_r;
          phase2_nxt    = 1'b0;
          best_ok_nxt   = 1'b0;
          best_size_nxt = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_r < hi_r) begin
          if ((scan_r != {1'b0, w_r}) && (size > best_size_r)) begin
            best_nxt      = sel;
            best_size_nxt = size;
            best_ok_nxt   = 1'b1;
          end
          scan_nxt = scan_r + 1'b1;
        end else if (best_ok_r) begin
          state_nxt = S_STEAL;
        end else if (!phase2_r) begin
          // first group offered nothing: search the rest
          phase2_nxt = 1'b1;
          scan_nxt   = g_r;
          hi_nxt     = n_r;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_STEAL: begin
        // take oldest task from the victim's top
        ram_re                = 1'b1;
        ram_raddr             = {sel, t_slot};
        top_we                = 1'b1;
        res_nxt.found         = 1'b1;
        res_nxt.stolen        = 1'b1;
        res_nxt.source_worker = wss_pkg::WORKER_W'(best_r);
        state_nxt             = S_READ;
      end
      S_READ: begin
        res_nxt.task_out = ram_rdata;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request and search registers
  always_ff @(posedge clk) begin
    if (start && (state_r == S_IDLE)) begin
      op_r   <= op;
      w_r    <= worker;
      task_r <= task_req;
      n_r    <= live_n;
      g_r    <= group_n;
    end
    scan_r      <= scan_nxt;
    hi_r        <= hi_nxt;
    phase2_r    <= phase2_nxt;
    best_r      <= best_nxt;
    best_ok_r   <= best_ok_nxt;
    best_size_r <= best_size_nxt;
    res_r       <= res_nxt;
  end

  // deque counters, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORKERS; i++) begin
        top_slot_r[i] <= '0;
        top_wrap_r[i] <= 1'b0;
        bot_slot_r[i] <= '0;
        bot_wrap_r[i] <= 1'b0;
      end
    end else begin
      if (top_we) begin
        top_slot_r[sel] <= top_wslot;
        top_wrap_r[sel] <= top_wwrap;
      end
      if (bot_we) begin
        bot_slot_r[sel] <= bot_wslot;
        bot_wrap_r[sel] <= bot_wwrap;
      end
    end
  end

  // task slot store, a block of 2**SW entries per worker that holds its ring of DEPTH slots
  wss_ram #(
    .WIDTH (wss_pkg::TASK_W),
    .DEPTH (2 ** AW)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (task_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

FILE: design/work_stealing_task_scheduler_top.sv
// top level of the work-stealing task scheduler
//
//  channel   dir  handshake          payload
//  in_req    in   valid/ready        operation, worker, task_req
//  out_res   out  valid/ready        found, task_out, source_worker, stolen, overflow
//  cfg_wr    in   valid/ready        index, data (workers_in_use, first_group_count)
//
// one request at a time. a push or an absent worker goes from the look-up state to
// the result; an own-deque pop also reads the slot ram; a steal searches the first
// group of g deques, then the other live deques if that group gives no victim, and a
// failed search visits all n live deques, since the size compare unit visits one
// deque per cycle in the victim search. in_req.ready returns in the cycle after the
// result moves to the output register, and a held output stalls the sequencer.
// the output register lets a new request in while a result waits to be taken.
// reset (rst_n low, synchronous) empties every deque; the slot ram needs no clearing.
// configuration writes are always taken.
module work_stealing_task_scheduler_top #(
  parameter int WORKERS = 8,
  parameter int DEPTH   = 64
) (
  input logic       clk,
  input logic       rst_n,
  wss_req_if.sink   in_req,
  wss_res_if.source out_res,
  wss_cfg_if.sink   cfg_wr
);

  localparam int CW = wss_pkg::CFG_DATA_W;

  logic [CW-1:0]    workers_in_use_r;
  logic [CW-1:0]    first_group_r;
  logic [CW-1:0]    live_n, group_n;
  logic             ctrl_ready, start;
  logic             res_valid, res_take;
  wss_pkg::result_t res;
  logic             out_valid_r;
  wss_pkg::result_t out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      workers_in_use_r <= wss_pkg::WORKERS_IN_USE_RST;
      first_group_r    <= wss_pkg::FIRST_GROUP_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        wss_pkg::CFG_WORKERS_IN_USE: workers_in_use_r <= cfg_wr.data;
        wss_pkg::CFG_FIRST_GROUP:    first_group_r    <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  // live deque count and clamped group boundary
  assign live_n  = (32'(workers_in_use_r) < WORKERS) ? workers_in_use_r : CW'(WORKERS);
  assign group_n = (first_group_r < live_n) ? first_group_r : live_n;

  assign in_req.ready = ctrl_ready;
  assign start        = in_req.valid && ctrl_ready;

  wss_ctrl #(
    .WORKERS (WORKERS),
    .DEPTH   (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .ready     (ctrl_ready),
    .op        (in_req.operation),
    .worker    (in_req.worker),
    .task_req  (in_req.task_req),
    .live_n    (live_n),
    .group_n   (group_n),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register
  assign res_take = res_valid && (!out_valid_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.found         = out_r.found;
  assign out_res.task_out      = out_r.task_out;
  assign out_res.source_worker = out_r.source_worker;
  assign out_res.stolen        = out_r.stolen;
  assign out_res.overflow      = out_r.overflow;

endmodule
